[hdl/swm_pkg.sv]
// swm_pkg: shared constants and types for the sliding window minimizer block
// used by swm_ctrl, swm_dp and sliding_window_minimizers; no dependencies
package swm_pkg;

  localparam int PRIME_BITS = 61;
  localparam int FP_W       = 61;
  localparam int POS_W      = 32;
  localparam int SYM_W      = 8;
  localparam int MAX_KMER   = 32;
  localparam int MAX_WIN    = 64;
  localparam int SYM_AW     = $clog2(MAX_KMER);
  localparam int Q_AW       = $clog2(MAX_WIN);
  localparam int CNT_W      = Q_AW + 1;
  localparam int K_W        = 6;
  localparam int WL_W       = 7;
  localparam int DIG_W      = 8;
  localparam int N_DIG      = (FP_W + DIG_W - 1) / DIG_W;
  localparam int DIG_CW     = $clog2(N_DIG);
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;

  localparam logic [FP_W-1:0] PRIME = {FP_W{1'b1}};

  // register indexes, from paddr[4:3]
  localparam logic [1:0] REG_KMER_LEN   = 2'd0;
  localparam logic [1:0] REG_WINDOW_LEN = 2'd1;
  localparam logic [1:0] REG_HASH_BASE  = 2'd2;
  localparam logic [1:0] REG_BASE_POW_K = 2'd3;

  typedef struct packed {
    logic [FP_W-1:0]  fp;
    logic [POS_W-1:0] pos;
  } qent_t;

  localparam int QENT_W = FP_W + POS_W;

  typedef struct packed {
    logic take;       // input request accepted
    logic mul_step;   // one digit of the rolling multiply
    logic add;        // add byte, compute leaving term, store byte
    logic sub;        // remove leaving term
    logic rd_back;    // queue read address at the back
    logic back_pop;
    logic front_pop;
    logic push;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic dig_zero;
    logic kmer_ready;
    logic count_zero;
    logic back_gt;
    logic front_expired;
    logic win_ready;
    logic dup;
    logic out_free;
  } sts_t;

endpackage

[hdl/swm_ram.sv]
// swm_ram: generic single write port, single read port ram with registered read
// no dependencies
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/swm_ctrl.sv]
// swm_ctrl: sequencer for one text byte: multiply, fingerprint update, queue upkeep, report
// depends on swm_pkg
module swm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swm_pkg::sts_t sts,
  output swm_pkg::cmd_t cmd
);
  import swm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_BRD  = 4'd4;
  localparam logic [3:0] S_BCMP = 4'd5;
  localparam logic [3:0] S_FRD  = 4'd6;
  localparam logic [3:0] S_FCMP = 4'd7;
  localparam logic [3:0] S_PUSH = 4'd8;
  localparam logic [3:0] S_HRD  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.dig_zero) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_BRD;
      end
      S_BRD: begin
        // kmer_ready looks at the updated byte count, valid from here on
        cmd.rd_back = 1'b1;
        if (!sts.kmer_ready) state_nxt = S_IDLE;
        else if (sts.count_zero) state_nxt = S_FRD;
        else state_nxt = S_BCMP;
      end
      S_BCMP: begin
        cmd.rd_back = 1'b1;
        if (sts.back_gt) begin
          cmd.back_pop = 1'b1;
          state_nxt    = S_BRD;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        if (sts.count_zero) state_nxt = S_PUSH;
        else state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (sts.front_expired) begin
          cmd.front_pop = 1'b1;
          state_nxt     = S_FRD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = sts.win_ready ? S_HRD : S_IDLE;
      end
      S_HRD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.dup) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/swm_dp.sv]
// swm_dp: rolling fingerprint arithmetic mod 2^61-1, byte history, monotonic queue, result register
// depends on swm_pkg and swm_ram
module swm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swm_pkg::cmd_t                cmd,
  output swm_pkg::sts_t                sts,
  input  logic [swm_pkg::K_W-1:0]      kmer_len,
  input  logic [swm_pkg::WL_W-1:0]     window_len,
  input  logic [swm_pkg::FP_W-1:0]     hash_base,
  input  logic [swm_pkg::FP_W-1:0]     base_pow_k,
  input  logic [swm_pkg::SYM_W-1:0]    in_symbol,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swm_pkg::POS_W-1:0]    out_minimizer_pos,
  output logic [swm_pkg::FP_W-1:0]     out_minimizer_fp
);
  import swm_pkg::*;

  // x*d mod P for a small digit d; x < P
  function automatic logic [FP_W-1:0] mul_red(input logic [FP_W-1:0] x,
                                             input logic [DIG_W-1:0] d);
    logic [FP_W+DIG_W-1:0] p;
    logic [FP_W:0]         s;
    begin
      p = {{DIG_W{1'b0}}, x} * {{FP_W{1'b0}}, d};
      s = {1'b0, p[FP_W-1:0]} + {{(FP_W+1-DIG_W){1'b0}}, p[FP_W+DIG_W-1:FP_W]};
      if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
      mul_red = s[FP_W-1:0];
    end
  endfunction

  function automatic logic [FP_W-1:0] mod_add(input logic [FP_W-1:0] a,
                                             input logic [FP_W-1:0] b);
    logic [FP_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
      mod_add = s[FP_W-1:0];
    end
  endfunction

  function automatic logic [FP_W-1:0] mod_sub(input logic [FP_W-1:0] a,
                                             input logic [FP_W-1:0] b);
    logic [FP_W:0] s;
    begin
      if (a >= b) s = {1'b0, a} - {1'b0, b};
      else s = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
      mod_sub = s[FP_W-1:0];
    end
  endfunction

  // effective k, window k-mer count
  logic [K_W-1:0]  k_eff;
  logic [WL_W-1:0] wl_eff;
  logic [WL_W-1:0] wk_raw;
  logic [CNT_W-1:0] wk;
  logic [FP_W-1:0] base_red;
  logic [FP_W-1:0] bpk_red;
  logic [N_DIG*DIG_W-1:0] base_pad;

  always_comb begin
    if (kmer_len == '0) k_eff = K_W'(1);
    else if (kmer_len > K_W'(MAX_KMER)) k_eff = K_W'(MAX_KMER);
    else k_eff = kmer_len;
    wl_eff = (window_len < {1'b0, k_eff}) ? {1'b0, k_eff} : window_len;
    wk_raw = wl_eff - {1'b0, k_eff} + WL_W'(1);
    wk     = (wk_raw > WL_W'(MAX_WIN)) ? CNT_W'(MAX_WIN) : CNT_W'(wk_raw);
    base_red = (hash_base == PRIME) ? '0 : hash_base;
    bpk_red  = (base_pow_k == PRIME) ? '0 : base_pow_k;
    base_pad = {{(N_DIG*DIG_W-FP_W){1'b0}}, base_red};
  end

  logic [FP_W-1:0]   rolling_fp_r, rolling_fp_nxt;
  logic [FP_W-1:0]   acc_r, acc_nxt;
  logic [FP_W-1:0]   fp_r, fp_nxt;
  logic [FP_W-1:0]   lv_r, lv_nxt;
  logic [DIG_CW-1:0] dig_r, dig_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [SYM_AW-1:0] sym_wr_r, sym_wr_nxt;
  logic [Q_AW-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  byte_count_r, byte_count_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  last_r, last_nxt;
  logic              emitted_r, emitted_nxt;
  logic              leave_en_r, leave_en_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [FP_W-1:0]   out_fp_r, out_fp_nxt;

  logic [SYM_AW-1:0] slot;
  logic [SYM_W-1:0]  old_sym;
  logic [Q_AW-1:0]   q_raddr;
  logic [Q_AW-1:0]   q_waddr;
  qent_t             q_rd;
  qent_t             q_wd;
  logic [QENT_W-1:0] q_rdata;
  logic [FP_W-1:0]   rot_acc;
  logic [DIG_W-1:0]  digit;
  logic [FP_W-1:0]   fp_final;

  assign slot    = sym_wr_r - k_eff[SYM_AW-1:0];
  assign q_raddr = cmd.rd_back ? (head_r + count_r[Q_AW-1:0] - Q_AW'(1)) : head_r;
  assign q_waddr = head_r + count_r[Q_AW-1:0];
  assign q_wd    = '{fp: fp_r, pos: idx_r};
  assign q_rd    = qent_t'(q_rdata);

  swm_ram #(.WIDTH(SYM_W), .DEPTH(MAX_KMER)) u_sym_ram (
    .clk   (clk),
    .we    (cmd.add),
    .waddr (sym_wr_r),
    .wdata (sym_r),
    .raddr (slot),
    .rdata (old_sym)
  );

  swm_ram #(.WIDTH(QENT_W), .DEPTH(MAX_WIN)) u_q_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (q_waddr),
    .wdata (q_wd),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // times 2^8 mod P is a rotation for a reduced value
  assign rot_acc  = {acc_r[FP_W-DIG_W-1:0], acc_r[FP_W-1:FP_W-DIG_W]};
  assign digit    = base_pad[dig_r*DIG_W +: DIG_W];
  assign fp_final = leave_en_r ? mod_sub(fp_r, lv_r) : fp_r;

  always_comb begin
    rolling_fp_nxt = rolling_fp_r;
    acc_nxt        = acc_r;
    fp_nxt         = fp_r;
    lv_nxt         = lv_r;
    dig_nxt        = dig_r;
    sym_nxt        = sym_r;
    sym_wr_nxt     = sym_wr_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    byte_count_nxt = byte_count_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    emitted_nxt    = emitted_r;
    leave_en_nxt   = leave_en_r;
    out_pos_nxt    = out_pos_r;
    out_fp_nxt     = out_fp_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (cmd.take) begin
      sym_nxt = in_symbol;
      acc_nxt = '0;
      dig_nxt = DIG_CW'(N_DIG - 1);
      if (in_restart) begin
        rolling_fp_nxt = '0;
        sym_wr_nxt     = '0;
        head_nxt       = '0;
        count_nxt      = '0;
        byte_count_nxt = '0;
        last_nxt       = '0;
        emitted_nxt    = 1'b0;
      end
    end
    if (cmd.mul_step) begin
      acc_nxt = mod_add(rot_acc, mul_red(rolling_fp_r, digit));
      dig_nxt = dig_r - DIG_CW'(1);
    end
    if (cmd.add) begin
      fp_nxt       = mod_add(acc_r, {{(FP_W-SYM_W){1'b0}}, sym_r});
      lv_nxt       = mul_red(bpk_red, old_sym);
      sym_wr_nxt   = sym_wr_r + SYM_AW'(1);
      leave_en_nxt = byte_count_r >= {{(POS_W-K_W){1'b0}}, k_eff};
      if (byte_count_r != {POS_W{1'b1}}) byte_count_nxt = byte_count_r + POS_W'(1);
    end
    if (cmd.sub) begin
      fp_nxt         = fp_final;
      rolling_fp_nxt = fp_final;
      idx_nxt        = byte_count_r - {{(POS_W-K_W){1'b0}}, k_eff};
    end
    if (cmd.back_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.front_pop) begin
      head_nxt  = head_r + Q_AW'(1);
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.push) begin
      // full queue only after positions saturate: drop the front
      if (count_r >= wk) head_nxt = head_r + Q_AW'(1);
      else count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = q_rd.pos;
      out_fp_nxt    = q_rd.fp;
      last_nxt      = q_rd.pos;
      emitted_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rolling_fp_r <= '0;
      sym_wr_r     <= '0;
      head_r       <= '0;
      count_r      <= '0;
      byte_count_r <= '0;
      last_r       <= '0;
      emitted_r    <= 1'b0;
      dig_r        <= '0;
      leave_en_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rolling_fp_r <= rolling_fp_nxt;
      sym_wr_r     <= sym_wr_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      byte_count_r <= byte_count_nxt;
      last_r       <= last_nxt;
      emitted_r    <= emitted_nxt;
      dig_r        <= dig_nxt;
      leave_en_r   <= leave_en_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    fp_r      <= fp_nxt;
    lv_r      <= lv_nxt;
    sym_r     <= sym_nxt;
    idx_r     <= idx_nxt;
    out_pos_r <= out_pos_nxt;
    out_fp_r  <= out_fp_nxt;
  end

  always_comb begin
    sts.dig_zero      = (dig_r == '0);
    sts.kmer_ready    = byte_count_r >= {{(POS_W-K_W){1'b0}}, k_eff};
    sts.count_zero    = (count_r == '0);
    sts.back_gt       = q_rd.fp > fp_r;
    sts.front_expired = ({1'b0, q_rd.pos} + {{(POS_W+1-CNT_W){1'b0}}, wk})
                        <= {1'b0, idx_r};
    sts.win_ready     = ({1'b0, idx_r} + (POS_W+1)'(1))
                        >= {{(POS_W+1-CNT_W){1'b0}}, wk};
    sts.dup           = emitted_r && (q_rd.pos == last_r);
    sts.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_minimizer_pos = out_pos_r;
  assign out_minimizer_fp  = out_fp_r;

endmodule

[hdl/sliding_window_minimizers.sv]
// sliding_window_minimizers: top level with register port, controller and datapath
// depends on swm_pkg, swm_ctrl, swm_dp (and swm_ram below it)
//
//  port group   direction  carries
//  in_*         in         text byte and restart flag, valid/ready
//  out_*        out        minimizer position and fingerprint, valid/ready
//  psel..pready in/out     registers kmer_len, window_len, hash_base, base_pow_k at 0,8,16,24
//
//  a new byte is accepted only when the previous one is finished. each byte runs
//  through the 8-bit-digit modular multiplier (8 passes, one per digit of
//  hash_base) and, once it completes a k-mer, the queue upkeep through the
//  single-read-port queue memory. a pending result stalls the report step only.
//  reset is synchronous; the history and queue memories are not cleared.
module sliding_window_minimizers (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swm_pkg::SYM_W-1:0]     in_symbol,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swm_pkg::POS_W-1:0]     out_minimizer_pos,
  output logic [swm_pkg::FP_W-1:0]      out_minimizer_fp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]    paddr,
  input  logic [swm_pkg::DATA_W-1:0]    pwdata,
  output logic [swm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import swm_pkg::*;

  logic [K_W-1:0]  kmer_len_r, kmer_len_nxt;
  logic [WL_W-1:0] window_len_r, window_len_nxt;
  logic [FP_W-1:0] hash_base_r, hash_base_nxt;
  logic [FP_W-1:0] base_pow_k_r, base_pow_k_nxt;
  logic [1:0]      reg_idx;
  logic            wr_en;
  cmd_t            cmd;
  sts_t            sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    kmer_len_nxt   = kmer_len_r;
    window_len_nxt = window_len_r;
    hash_base_nxt  = hash_base_r;
    base_pow_k_nxt = base_pow_k_r;
    if (wr_en) begin
      case (reg_idx)
        REG_KMER_LEN:   kmer_len_nxt   = pwdata[K_W-1:0];
        REG_WINDOW_LEN: window_len_nxt = pwdata[WL_W-1:0];
        REG_HASH_BASE:  hash_base_nxt  = pwdata[FP_W-1:0];
        REG_BASE_POW_K: base_pow_k_nxt = pwdata[FP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r   <= K_W'(16);
      window_len_r <= WL_W'(24);
      hash_base_r  <= FP_W'(256);
      base_pow_k_r <= FP_W'(1);
    end else begin
      kmer_len_r   <= kmer_len_nxt;
      window_len_r <= window_len_nxt;
      hash_base_r  <= hash_base_nxt;
      base_pow_k_r <= base_pow_k_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KMER_LEN:   prdata = {{(DATA_W-K_W){1'b0}}, kmer_len_r};
      REG_WINDOW_LEN: prdata = {{(DATA_W-WL_W){1'b0}}, window_len_r};
      REG_HASH_BASE:  prdata = {{(DATA_W-FP_W){1'b0}}, hash_base_r};
      REG_BASE_POW_K: prdata = {{(DATA_W-FP_W){1'b0}}, base_pow_k_r};
      default:        prdata = '0;
    endcase
  end

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .kmer_len          (kmer_len_r),
    .window_len        (window_len_r),
    .hash_base         (hash_base_r),
    .base_pow_k        (base_pow_k_r),
    .in_symbol         (in_symbol),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_minimizer_pos (out_minimizer_pos),
    .out_minimizer_fp  (out_minimizer_fp)
  );

  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (!sts.dup && sts.out_free))
    else $error("result loaded while duplicate or output busy");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> !sts.count_zero)
    else $error("queue empty after push");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_restart) |=> sts.count_zero)
    else $error("queue not cleared by restart");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.back_pop || cmd.front_pop) |-> !sts.count_zero)
    else $error("pop from empty queue");

endmodule
